>>> src/spq_pkg.sv
// ---------------------------------------------------------------------------
// spq_pkg: shared definitions for the sorted priority queue
// Operation codes, field widths and the control bundle broadcast to cells.
// ---------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

   localparam int SPQ_CAPACITY = 256;
   localparam int WEIGHT_W     = 32;
   localparam int HANDLE_W     = 9;
   localparam int COUNT_OUT_W  = 9;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_REMOVE = 1'b1;

   // control broadcast to every cell in the chain
   typedef struct packed {
      logic                ins;
      logic                rem;
      logic [WEIGHT_W-1:0] weight;
      logic [HANDLE_W-1:0] handle;
   } spq_ctl_type;

endpackage

`default_nettype wire

>>> src/sorted_priority_queue.sv
// ---------------------------------------------------------------------------
// sorted_priority_queue: min-priority queue in a shift chain of cells
// A result is registered and shown in the cycle after its item is accepted.
// Throughput: one item per cycle; every cell compares and shifts in parallel.
// The output register decouples the sides; req_ready drops only while a
// result is held and rsp_ready is low.
// Reset: synchronous; clears the count and rsp_valid, no sweep needed.
// ---------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue
   import spq_pkg::*;
#(
   parameter int CAPACITY = SPQ_CAPACITY
)
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   req_func,
   input  wire logic [WEIGHT_W-1:0]    req_weight,
   input  wire logic [HANDLE_W-1:0]    req_handle,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic                        rsp_out_valid,
   output logic [WEIGHT_W-1:0]         rsp_out_weight,
   output logic [HANDLE_W-1:0]         rsp_out_handle,
   output logic                        rsp_overflow,
   output logic [COUNT_OUT_W-1:0]      rsp_entry_count,
   output logic                        rsp_is_empty
);

   localparam int CW = $clog2(CAPACITY + 1);

   // count of held entries; cell i is occupied when i < count
   logic [CW-1:0] count_ff, count_in;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   out_valid_ff, out_valid_in;
   logic [WEIGHT_W-1:0]    out_weight_ff, out_weight_in;
   logic [HANDLE_W-1:0]    out_handle_ff, out_handle_in;
   logic                   overflow_ff, overflow_in;
   logic [CW-1:0]          rcount_ff;

   logic req_fire, full, empty;
   spq_ctl_type ctl;

   // chain wiring
   logic                cell_here   [CAPACITY];
   logic [WEIGHT_W-1:0] cell_weight [CAPACITY];
   logic [HANDLE_W-1:0] cell_handle [CAPACITY];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign full      = (count_ff == CW'(CAPACITY));
   assign empty     = (count_ff == '0);

   assign ctl.ins    = req_fire && (req_func == FUNC_INSERT) && !full;
   assign ctl.rem    = req_fire && (req_func == FUNC_REMOVE) && !empty;
   assign ctl.weight = req_weight;
   assign ctl.handle = req_handle;

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         localparam logic [CW-1:0] IDX = CW'(gi);
         logic                occ;
         logic                lh;
         logic [WEIGHT_W-1:0] lw, rw;
         logic [HANDLE_W-1:0] lhd, rhd;

         assign occ = (IDX < count_ff);

         if (gi == 0) begin : g_head
            // nothing to the left of the head
            assign lh  = 1'b0;
            assign lw  = '0;
            assign lhd = '0;
         end else begin : g_body
            assign lh  = cell_here[gi-1];
            assign lw  = cell_weight[gi-1];
            assign lhd = cell_handle[gi-1];
         end

         if (gi == CAPACITY - 1) begin : g_tail
            // slot vacated by a remove; its contents are never read
            assign rw  = '0;
            assign rhd = '0;
         end else begin : g_mid
            assign rw  = cell_weight[gi+1];
            assign rhd = cell_handle[gi+1];
         end

         spq_cell u_cell (
            .clock        (clock),
            .ctl          (ctl),
            .occ          (occ),
            .left_here    (lh),
            .left_weight  (lw),
            .left_handle  (lhd),
            .right_weight (rw),
            .right_handle (rhd),
            .here         (cell_here[gi]),
            .weight       (cell_weight[gi]),
            .handle       (cell_handle[gi])
         );
      end
   endgenerate

   always_comb begin
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff;
      out_valid_in  = out_valid_ff;
      out_weight_in = out_weight_ff;
      out_handle_in = out_handle_ff;
      overflow_in   = overflow_ff;

      if (rsp_valid_ff && rsp_ready)
         rsp_valid_in = 1'b0;

      if (req_fire) begin
         rsp_valid_in  = 1'b1;
         out_valid_in  = 1'b0;
         out_weight_in = '0;
         out_handle_in = '0;
         overflow_in   = 1'b0;
         if (req_func == FUNC_INSERT) begin
            if (full)
               overflow_in = 1'b1;
            else
               count_in = count_ff + CW'(1);
         end else if (!empty) begin
            // head cell holds the least weight
            out_valid_in  = 1'b1;
            out_weight_in = cell_weight[0];
            out_handle_in = cell_handle[0];
            count_in      = count_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      out_valid_ff  <= out_valid_in;
      out_weight_ff <= out_weight_in;
      out_handle_ff <= out_handle_in;
      overflow_ff   <= overflow_in;
      if (req_fire)
         rcount_ff <= count_in;
   end

   // count reported masked to the field width
   logic [CW+COUNT_OUT_W-1:0] rcount_ext;
   assign rcount_ext = {{COUNT_OUT_W{1'b0}}, rcount_ff};

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_valid   = out_valid_ff;
   assign rsp_out_weight  = out_weight_ff;
   assign rsp_out_handle  = out_handle_ff;
   assign rsp_overflow    = overflow_ff;
   assign rsp_entry_count = rcount_ext[COUNT_OUT_W-1:0];
   assign rsp_is_empty    = (rcount_ff == '0);

endmodule

`default_nettype wire

>>> src/spq_cell.sv
// ---------------------------------------------------------------------------
// spq_cell: one slot of the sorted shift chain
// Holds one entry; on insert takes the left entry, the new entry or keeps its
// own; on remove takes the right entry.
// ---------------------------------------------------------------------------
`default_nettype none

module spq_cell
   import spq_pkg::*;
(
   input  wire logic                clock,
   input  wire spq_ctl_type         ctl,
   input  wire logic                occ,
   input  wire logic                left_here,
   input  wire logic [WEIGHT_W-1:0] left_weight,
   input  wire logic [HANDLE_W-1:0] left_handle,
   input  wire logic [WEIGHT_W-1:0] right_weight,
   input  wire logic [HANDLE_W-1:0] right_handle,
   output logic                     here,
   output logic [WEIGHT_W-1:0]      weight,
   output logic [HANDLE_W-1:0]      handle
);

   logic [WEIGHT_W-1:0] weight_ff, weight_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;

   // new entry belongs at or before this slot (ties go ahead)
   assign here = !occ || (ctl.weight <= weight_ff);

   always_comb begin
      weight_in = weight_ff;
      handle_in = handle_ff;
      if (ctl.ins) begin
         if (left_here) begin
            weight_in = left_weight;
            handle_in = left_handle;
         end else if (here) begin
            weight_in = ctl.weight;
            handle_in = ctl.handle;
         end
      end else if (ctl.rem) begin
         weight_in = right_weight;
         handle_in = right_handle;
      end
   end

   always_ff @(posedge clock) begin
      weight_ff <= weight_in;
      handle_ff <= handle_in;
   end

   assign weight = weight_ff;
   assign handle = handle_ff;

endmodule

`default_nettype wire

>>> src/spq_checker.sv
// ---------------------------------------------------------------------------
// spq_checker: port-level checks for the sorted priority queue
// Watches the result channel for consistency of the reported fields.
// ---------------------------------------------------------------------------
`default_nettype none

module spq_checker
   import spq_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire logic                   rsp_out_valid,
   input wire logic [WEIGHT_W-1:0]    rsp_out_weight,
   input wire logic [HANDLE_W-1:0]    rsp_out_handle,
   input wire logic                   rsp_overflow,
   input wire logic [COUNT_OUT_W-1:0] rsp_entry_count,
   input wire logic                   rsp_is_empty
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_weight)
         && $stable(rsp_out_handle) && $stable(rsp_entry_count))
      else $error("result item changed while stalled");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> rsp_entry_count == '0)
      else $error("empty result with nonzero count");

   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_out_valid && rsp_overflow))
      else $error("remove result flagged overflow");

   a_zero_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_valid |-> rsp_out_weight == '0 && rsp_out_handle == '0)
      else $error("non-remove result carries entry data");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> !rsp_is_empty)
      else $error("overflow reported on empty queue");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);

`default_nettype wire
